/* rtl/double_ended_list_store_defines.svh */
// assertion macros for the rtl files, included by the datapath
`ifndef DOUBLE_ENDED_LIST_STORE_DEFINES_SVH
`define DOUBLE_ENDED_LIST_STORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked on every clock edge outside reset
`define DELS_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("%m: assertion failed");

// checked on every clock edge, reset included
`define DELS_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) (expr)) \
        else $error("%m: assertion failed");

`else

`define DELS_ASSERT(lbl, expr)
`define DELS_ASSERT_ALWAYS(lbl, expr)

`endif

`endif

/* rtl/dels_pkg.sv */
package dels_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W     = 32;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int TDATA_IN_W = 32;
    localparam int TDATA_OUT_W = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_CLEAR      = 3'd4,
        MODE_READ_ALL   = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_LD,
        S_DUMP_RD,
        S_DUMP_LD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    push_front;
        logic    push_back;
        logic    pop_front;
        logic    pop_back;
        logic    clear;
        logic    dump_rd;
        logic    idx_clr;
        logic    idx_inc;
        logic    load_zero;
        logic    load_ram;
        logic    last;
        status_t status;
    } dels_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic dump_last;
        logic out_free;
    } dels_stat_t;

endpackage

/* rtl/dels_ram.sv */
module dels_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/dels_ctrl.sv */
module dels_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic [dels_pkg::MODE_W-1:0]  mode,
    output logic                         s_tready,
    input  dels_pkg::dels_stat_t         stat,
    output dels_pkg::dels_cmd_t          cmd
);

    import dels_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (mode) inside
                        MODE_POP_FRONT, MODE_POP_BACK: begin
                            if (!stat.empty) state_next = S_POP_LD;
                        end
                        MODE_READ_ALL: begin
                            if (!stat.empty) state_next = S_DUMP_RD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_POP_LD: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            S_DUMP_RD: begin
                state_next = S_DUMP_LD;
            end
            S_DUMP_LD: begin
                if (stat.out_free) state_next = stat.dump_last ? S_IDLE : S_DUMP_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd        = '0;
        cmd.status = STAT_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (mode) inside
                        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                            cmd.load_zero = 1'b1;
                            cmd.last      = 1'b1;
                            if (stat.full) begin
                                cmd.status = STAT_FULL;
                            end else if (mode == MODE_PUSH_FRONT) begin
                                cmd.push_front = 1'b1;
                            end else begin
                                cmd.push_back = 1'b1;
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_BACK: begin
                            if (stat.empty) begin
                                cmd.load_zero = 1'b1;
                                cmd.last      = 1'b1;
                                cmd.status    = STAT_EMPTY;
                            end else if (mode == MODE_POP_FRONT) begin
                                cmd.pop_front = 1'b1;
                            end else begin
                                cmd.pop_back = 1'b1;
                            end
                        end
                        MODE_CLEAR: begin
                            cmd.clear     = 1'b1;
                            cmd.load_zero = 1'b1;
                            cmd.last      = 1'b1;
                        end
                        MODE_READ_ALL: begin
                            if (stat.empty) begin
                                cmd.load_zero = 1'b1;
                                cmd.last      = 1'b1;
                                cmd.status    = STAT_EMPTY;
                            end else begin
                                cmd.idx_clr = 1'b1;
                            end
                        end
                        default: begin
                            cmd.load_zero = 1'b1;
                            cmd.last      = 1'b1;
                        end
                    endcase
                end
            end
            S_POP_LD: begin
                if (stat.out_free) begin
                    cmd.load_ram = 1'b1;
                    cmd.last     = 1'b1;
                end
            end
            S_DUMP_RD: begin
                cmd.dump_rd = 1'b1;
            end
            S_DUMP_LD: begin
                if (stat.out_free) begin
                    cmd.load_ram = 1'b1;
                    cmd.last     = stat.dump_last;
                    cmd.idx_inc  = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

/* rtl/dels_dp.sv */
`include "double_ended_list_store_defines.svh"

module dels_dp #(
    parameter int DEPTH = dels_pkg::DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dels_pkg::dels_cmd_t            cmd,
    output dels_pkg::dels_stat_t           stat,
    input  logic [dels_pkg::DATA_W-1:0]    value,
    input  logic                           m_tready,
    output logic                           out_valid,
    output logic [dels_pkg::DATA_W-1:0]    out_value,
    output logic [dels_pkg::STATUS_W-1:0]  out_status,
    output logic [dels_pkg::COUNT_W-1:0]   out_count,
    output logic                           out_last
);

    import dels_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [PTR_W-1:0]    idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_value_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_last_reg;

    logic [PTR_W-1:0]    front_dec, front_inc;
    logic                wr_en, rd_en;
    logic [PTR_W-1:0]    wr_addr, rd_addr;
    logic [DATA_W-1:0]   rd_data;

    // ring position base + off, both below DEPTH
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PTR_W+1)'(DEPTH)) sum = sum - (PTR_W+1)'(DEPTH);
        return sum[PTR_W-1:0];
    endfunction

    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = slot_of(front_reg, PTR_W'(1));

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CNT_W'(DEPTH));
    assign stat.dump_last = (CNT_W'(idx_reg) + 1'b1 == count_reg);
    assign stat.out_free  = !out_valid_reg || m_tready;

    // entry store access
    assign wr_en   = cmd.push_front || cmd.push_back;
    assign wr_addr = cmd.push_front ? front_dec : slot_of(front_reg, PTR_W'(count_reg));
    assign rd_en   = cmd.pop_front || cmd.pop_back || cmd.dump_rd;

    always_comb begin
        if (cmd.pop_front) begin
            rd_addr = front_reg;
        end else if (cmd.pop_back) begin
            rd_addr = slot_of(front_reg, PTR_W'(count_reg - 1'b1));
        end else begin
            rd_addr = slot_of(front_reg, idx_reg);
        end
    end

    dels_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        if (cmd.clear) begin
            front_next = '0;
            count_next = '0;
        end
        if (cmd.push_front) front_next = front_dec;
        if (cmd.pop_front)  front_next = front_inc;
        if (cmd.push_front || cmd.push_back) count_next = count_reg + 1'b1;
        if (cmd.pop_front || cmd.pop_back)   count_next = count_reg - 1'b1;
        if (cmd.idx_clr) idx_next = '0;
        if (cmd.idx_inc) idx_next = idx_reg + 1'b1;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_zero || cmd.load_ram) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_zero || cmd.load_ram) begin
            out_value_reg  <= cmd.load_ram ? rd_data : '0;
            out_status_reg <= cmd.status;
            out_count_reg  <= COUNT_W'(count_next);
            out_last_reg   <= cmd.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;
    assign out_last   = out_last_reg;

    `DELS_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH))
    `DELS_ASSERT(a_front_bound, front_reg <= PTR_W'(DEPTH - 1))
    `DELS_ASSERT(a_no_push_full, (cmd.push_front || cmd.push_back) |-> !stat.full)
    `DELS_ASSERT(a_no_pop_empty, (cmd.pop_front || cmd.pop_back) |-> !stat.empty)
    `DELS_ASSERT(a_load_free, (cmd.load_zero || cmd.load_ram) |-> stat.out_free)
    `DELS_ASSERT(a_pop_then_load, (cmd.pop_front || cmd.pop_back) |=> !rd_en)

endmodule

/* rtl/double_ended_list_store.sv */
// double-ended list store: bounded ring of signed 32-bit entries, one command per word
// push, clear, refused commands: result valid in the cycle after accept; next one needs a free output
// pop: registered entry store read, then output load once free; next command after the load
// read all: store read then output load for each entry, front to back; next command after the last
// synchronous active-low reset empties the list; stored entries are kept, never cleared
module double_ended_list_store #(
    parameter int DEPTH = dels_pkg::DEPTH_DEF  // ring slots, 2 to 31
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // command channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dels_pkg::TDATA_IN_W-1:0]   s_tdata,   // value[31:0]
    input  logic [dels_pkg::MODE_W-1:0]       s_tuser,   // mode[2:0]

    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dels_pkg::TDATA_OUT_W-1:0]  m_tdata,   // value_res[31:0], count[36:32], zero pad
    output logic [dels_pkg::STATUS_W-1:0]     m_tuser,   // status[1:0]
    output logic                              m_tlast    // last result of the command
);

    import dels_pkg::*;

    dels_cmd_t           cmd;
    dels_stat_t          stat;
    logic [DATA_W-1:0]   out_value;
    logic [COUNT_W-1:0]  out_count;

    // sequencer: decodes the mode, walks pops and read-outs through the store
    dels_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .mode     (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // ring pointers, entry store and output register
    dels_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .value      (s_tdata[DATA_W-1:0]),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_value  (out_value),
        .out_status (m_tuser),
        .out_count  (out_count),
        .out_last   (m_tlast)
    );

    // pack result word, pad to whole bytes
    assign m_tdata = {{(TDATA_OUT_W - DATA_W - COUNT_W){1'b0}}, out_count, out_value};

endmodule

/* tb/dels_reply_checker.sv */
`timescale 1ns / 1ps

// watches both channels, keeps its own copy of the list and checks every result word
module dels_reply_checker
    import dels_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [TDATA_IN_W-1:0]   s_tdata,   // value[31:0]
    input  logic [MODE_W-1:0]       s_tuser,   // mode[2:0]
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [TDATA_OUT_W-1:0]  m_tdata,   // value_res[31:0], count[36:32], zero pad
    input  logic [STATUS_W-1:0]     m_tuser,   // status[1:0]
    input  logic                    m_tlast,
    output int                      fail_count,
    output int                      words_waiting
);

    localparam int LIST_DEPTH = DEPTH_DEF;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic               last;
    } reply_t;

    // shadow copy of the ring
    logic [DATA_W-1:0] ring [LIST_DEPTH];
    int                head;
    int                fill;
    int                errors = 0;

    reply_t list_replies [$];

    function automatic void apply_list_command(input logic [MODE_W-1:0] md,
                                               input logic [DATA_W-1:0] val);
        reply_t r;
        int     i;
        r.value  = '0;
        r.status = STAT_OK;
        r.last   = 1'b1;
        case (md)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (fill >= LIST_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    if (md == MODE_PUSH_FRONT) begin
                        head       = (head + LIST_DEPTH - 1) % LIST_DEPTH;
                        ring[head] = val;
                    end else begin
                        ring[(head + fill) % LIST_DEPTH] = val;
                    end
                    fill++;
                end
            end
            MODE_POP_FRONT: begin
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.value = ring[head];
                    head    = (head + 1) % LIST_DEPTH;
                    fill--;
                end
            end
            MODE_POP_BACK: begin
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.value = ring[(head + fill - 1) % LIST_DEPTH];
                    fill--;
                end
            end
            MODE_CLEAR: begin
                fill = 0;
                head = 0;
            end
            MODE_READ_ALL: begin
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    // one word per entry, front to back, last flag on the final one
                    for (i = 0; i < fill; i++) begin
                        r.value = ring[(head + i) % LIST_DEPTH];
                        r.count = COUNT_W'(fill);
                        r.last  = (i == fill - 1);
                        list_replies.push_back(r);
                    end
                    return;
                end
            end
            default: ;
        endcase
        r.count = COUNT_W'(fill);
        list_replies.push_back(r);
    endfunction

    function automatic void check_field(input string what, input logic [DATA_W-1:0] exp_v,
                                        input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            head = 0;
            fill = 0;
            list_replies.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (list_replies.size() == 0) begin
                    $display("%0t: result word with nothing expected, expected none, actual %h %h %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    want = list_replies.pop_front();
                    check_field("value", want.value, m_tdata[DATA_W-1:0]);
                    check_field("count", DATA_W'(want.count), DATA_W'(m_tdata[DATA_W +: COUNT_W]));
                    check_field("pad", '0, DATA_W'(m_tdata[TDATA_OUT_W-1:DATA_W+COUNT_W]));
                    check_field("status", DATA_W'(want.status), DATA_W'(m_tuser));
                    check_field("last", DATA_W'(want.last), DATA_W'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                apply_list_command(s_tuser, s_tdata);
        end
        words_waiting <= list_replies.size();
        fail_count    <= errors;
    end

endmodule

/* tb/tb_double_ended_list_store.sv */
`timescale 1ns / 1ps

// drives commands into the list store, takes result words with random back-pressure
// and leaves all checking to the checker instance
module tb_double_ended_list_store;
    import dels_pkg::*;

    // the two mode codes the block does not use
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam int RANDOM_WORDS = 400;
    localparam int CYCLE_LIMIT  = 300000;  // far above the slowest legal run
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int TAIL_CYCLES  = 50;      // quiet cycles after the last result
    localparam int IDLE_PCT     = 37;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [TDATA_IN_W-1:0]   s_tdata;   // value[31:0]
    logic [MODE_W-1:0]       s_tuser;   // mode[2:0]
    logic                    m_tvalid;
    logic                    m_tready;
    logic [TDATA_OUT_W-1:0]  m_tdata;   // value_res[31:0], count[36:32], zero pad
    logic [STATUS_W-1:0]     m_tuser;   // status[1:0]
    logic                    m_tlast;

    int fail_count;
    int words_waiting;
    int cycles = 0;

    // shared knobs between stimulus and receiver
    bit gaps_on  = 1'b1;
    bit hold_req = 1'b0;

    double_ended_list_store dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    dels_reply_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .words_waiting (words_waiting)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver side: random ready, one long hold-off while the sender keeps offering
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                // the result word stays pending behind this and the block must stall its input
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // offer one command word and hold it until it is taken
    task automatic send_word(input logic [MODE_W-1:0] md, input logic [DATA_W-1:0] val);
        // random gaps before the word, skipped in the no-idle stretch
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= md;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        int                  n;
        int                  i;
        int                  roll;
        int                  push_pct;
        logic [MODE_W-1:0]   md;
        logic [DATA_W-1:0]   val;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty list corner cases
        send_word(MODE_POP_FRONT, 32'h0000_0000);
        send_word(MODE_POP_BACK, 32'hFFFF_FFFF);
        send_word(MODE_READ_ALL, 32'h0000_0000);
        send_word(MODE_CLEAR, 32'h0000_0000);     // clear on an already empty list
        send_word(MODE_SPARE_LO, 32'h5555_5555);  // unused modes leave the list unchanged
        send_word(MODE_SPARE_HI, 32'hAAAA_AAAA);
        // back push into an empty list, then back pop of a single entry
        send_word(MODE_PUSH_BACK, 32'h8000_0000);
        send_word(MODE_POP_BACK, 32'h0000_0000);
        // fill to the brim with value extremes at both ends
        send_word(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
        send_word(MODE_PUSH_BACK, 32'h8000_0000);
        for (i = 0; i < DEPTH_DEF - 2; i++)
            send_word(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK, $urandom);
        // pushes on a full list get refused
        send_word(MODE_PUSH_FRONT, 32'h0000_0001);
        send_word(MODE_PUSH_BACK, 32'h0000_0001);
        send_word(MODE_READ_ALL, 32'h0000_0000);
        send_word(MODE_POP_FRONT, 32'h0000_0000);
        send_word(MODE_POP_BACK, 32'h0000_0000);

        // random: phases that lean toward filling, draining or balance
        push_pct = 50;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 30 == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 85;
                    1:       push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            gaps_on = !(n >= 120 && n < 200);  // no-idle stretch
            if (n == 250)
                hold_req = 1'b1;

            // entry values: mostly random, sometimes an extreme
            case ($urandom_range(9))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                default: val = $urandom;
            endcase

            roll = $urandom_range(99);
            if (roll < 3)
                md = $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
            else if (roll < 6)
                md = MODE_CLEAR;
            else if (roll < 14)
                md = MODE_READ_ALL;
            else if ($urandom_range(99) < push_pct)
                md = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            else
                md = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
            send_word(md, val);
        end
        s_tvalid <= 1'b0;
        gaps_on = 1'b1;

        // drain: the count seen here is registered in the checker, so wait for a clock edge first
        @(posedge aclk);
        while (words_waiting != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && words_waiting == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/dels_pkg.sv
rtl/dels_ram.sv
rtl/dels_ctrl.sv
rtl/dels_dp.sv
rtl/double_ended_list_store.sv
tb/dels_reply_checker.sv
tb/tb_double_ended_list_store.sv
